[rtl/lcc_pkg.sv]
// Package for the chunk cache lookup unit: sizes, field widths, opcode and status codes.
// No dependencies.
package lcc_pkg;

  localparam int CHUNK_BYTES = 4096;
  localparam int NUM_ENTRIES = 16;
  localparam int ADDR_BITS   = 32;

  localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);
  localparam int TAG_BITS    = ADDR_BITS - CHUNK_SHIFT;
  localparam int SLOT_BITS   = $clog2(NUM_ENTRIES);
  localparam int FILL_BITS   = $clog2(NUM_ENTRIES + 1);
  localparam int ROOM_BITS   = CHUNK_SHIFT + 1;

  localparam int OFFSET_W    = 32;
  localparam int STATUS_W    = 2;
  localparam int SLOT_W      = 4;
  localparam int COFF_W      = 12;
  localparam int OLEN_W      = 13;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_SERVED   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CLEARED  = 2'd2;

  typedef logic [TAG_BITS-1:0]  tag_t;
  typedef logic [SLOT_BITS-1:0] rank_t;
  typedef logic [SLOT_BITS-1:0] slot_idx_t;

endpackage

[rtl/lru_chunk_cache_lookup_unit.sv]
// Tag store and LRU control for a fully associative cache of aligned file chunks.
// Depends on lcc_pkg.
//
// Channel   Ports                                            Handshake
// request   opcode offset length                             start && !busy
// result    status hit slot fetch_base evicted evicted_base  done, one cycle, no stall
//           chunk_offset out_length
// config    cfg_data (file size)                             cfg_we
//
// One request per cycle while busy is low; a result is on the ports once its request has
// passed the input register, then tag compare and rank update into the result register.
// Reset clears valid bits, ranks and fill count at once; busy is high for the
// cycle after reset. The receiver cannot stall, so nothing holds results back.
module lru_chunk_cache_lookup_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [31:0] offset,
  input  logic [31:0] length,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic        hit,
  output logic [3:0]  slot,
  output logic [31:0] fetch_base,
  output logic        evicted,
  output logic [31:0] evicted_base,
  output logic [11:0] chunk_offset,
  output logic [12:0] out_length
);

  localparam lcc_pkg::rank_t RANK_MAX = lcc_pkg::SLOT_BITS'(lcc_pkg::NUM_ENTRIES - 1);

  logic [31:0] file_size;

  logic        req_valid;
  logic        req_opcode;
  logic [31:0] req_offset;
  logic [31:0] req_length;

  lcc_pkg::tag_t  entry_tag  [lcc_pkg::NUM_ENTRIES];
  lcc_pkg::rank_t entry_rank [lcc_pkg::NUM_ENTRIES];
  lcc_pkg::rank_t rank_next  [lcc_pkg::NUM_ENTRIES];
  logic [lcc_pkg::NUM_ENTRIES-1:0] entry_valid, valid_next;
  logic [lcc_pkg::FILL_BITS-1:0]   fill_count, fill_next;

  logic [lcc_pkg::NUM_ENTRIES-1:0] match, is_worst;
  lcc_pkg::tag_t      req_tag;
  logic               reject, is_hit, has_free, tag_we;
  lcc_pkg::slot_idx_t hit_idx, free_idx, worst_idx, victim, slot_sel;
  lcc_pkg::rank_t     hit_rank;
  logic [31:0]        avail, len_a;
  logic [lcc_pkg::CHUNK_SHIFT-1:0] coff;
  logic [lcc_pkg::ROOM_BITS-1:0]   room;
  logic [lcc_pkg::ADDR_BITS-1:0]   base, ev_base;

  logic        done_next, hit_next, evicted_next;
  logic [1:0]  status_next;
  logic [3:0]  slot_next;
  logic [31:0] fetch_base_next, evicted_base_next;
  logic [11:0] coff_next;
  logic [12:0] olen_next;

  assign req_tag = lcc_pkg::TAG_BITS'(req_offset >> lcc_pkg::CHUNK_SHIFT);
  assign base    = {req_tag, {lcc_pkg::CHUNK_SHIFT{1'b0}}};
  assign coff    = req_offset[lcc_pkg::CHUNK_SHIFT-1:0];
  assign room    = lcc_pkg::ROOM_BITS'(lcc_pkg::CHUNK_BYTES) - {1'b0, coff};
  assign avail   = file_size - req_offset;
  assign len_a   = (req_length < avail) ? req_length : avail;
  assign reject  = (req_length == 32'd0) || (req_offset >= file_size);
  assign has_free = fill_count < lcc_pkg::FILL_BITS'(lcc_pkg::NUM_ENTRIES);

  always_comb begin
    for (int i = 0; i < lcc_pkg::NUM_ENTRIES; i++) begin
      match[i]    = entry_valid[i] && (entry_tag[i] == req_tag);
      is_worst[i] = 1'b1;
      for (int j = 0; j < lcc_pkg::NUM_ENTRIES; j++) begin
        if (j < i && entry_rank[j] > entry_rank[i]) begin
          is_worst[i] = 1'b0;
        end
        if (j > i && entry_rank[j] >= entry_rank[i]) begin
          is_worst[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    hit_idx   = '0;
    free_idx  = '0;
    worst_idx = '0;
    for (int i = lcc_pkg::NUM_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = lcc_pkg::SLOT_BITS'(i);
      end
      if (!entry_valid[i]) begin
        free_idx = lcc_pkg::SLOT_BITS'(i);
      end
      if (is_worst[i]) begin
        worst_idx = lcc_pkg::SLOT_BITS'(i);
      end
    end
  end

  assign is_hit   = |match;
  assign hit_rank = entry_rank[hit_idx];
  assign victim   = has_free ? free_idx : worst_idx;
  assign slot_sel = is_hit ? hit_idx : victim;
  assign ev_base  = {entry_tag[victim], {lcc_pkg::CHUNK_SHIFT{1'b0}}};

  always_comb begin
    valid_next        = entry_valid;
    rank_next         = entry_rank;
    fill_next         = fill_count;
    tag_we            = 1'b0;
    done_next         = req_valid;
    status_next       = lcc_pkg::STATUS_SERVED;
    hit_next          = 1'b0;
    slot_next         = '0;
    fetch_base_next   = '0;
    evicted_next      = 1'b0;
    evicted_base_next = '0;
    coff_next         = '0;
    olen_next         = '0;
    if (req_valid) begin
      if (req_opcode == lcc_pkg::OP_CLEAR) begin
        status_next = lcc_pkg::STATUS_CLEARED;
        valid_next  = '0;
        fill_next   = '0;
        for (int i = 0; i < lcc_pkg::NUM_ENTRIES; i++) begin
          rank_next[i] = '0;
        end
      end else if (reject) begin
        status_next = lcc_pkg::STATUS_REJECTED;
      end else begin
        hit_next        = is_hit;
        slot_next       = lcc_pkg::SLOT_W'(slot_sel);
        fetch_base_next = 32'(base);
        coff_next       = lcc_pkg::COFF_W'(coff);
        olen_next       = (len_a > 32'(room)) ? lcc_pkg::OLEN_W'(room)
                                              : lcc_pkg::OLEN_W'(len_a);
        if (is_hit) begin
          for (int i = 0; i < lcc_pkg::NUM_ENTRIES; i++) begin
            if (entry_valid[i] && entry_rank[i] < hit_rank) begin
              rank_next[i] = entry_rank[i] + 1'b1;
            end
          end
          rank_next[hit_idx] = '0;
        end else begin
          evicted_next      = !has_free;
          evicted_base_next = has_free ? 32'd0 : 32'(ev_base);
          for (int i = 0; i < lcc_pkg::NUM_ENTRIES; i++) begin
            if (entry_valid[i] && entry_rank[i] < RANK_MAX) begin
              rank_next[i] = entry_rank[i] + 1'b1;
            end
          end
          rank_next[victim]  = '0;
          valid_next[victim] = 1'b1;
          tag_we             = 1'b1;
          if (has_free) begin
            fill_next = fill_count + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b1;
      file_size   <= '0;
      req_valid   <= 1'b0;
      entry_valid <= '0;
      fill_count  <= '0;
      done        <= 1'b0;
      for (int i = 0; i < lcc_pkg::NUM_ENTRIES; i++) begin
        entry_rank[i] <= '0;
      end
    end else begin
      busy        <= 1'b0;
      if (cfg_we) begin
        file_size <= cfg_data;
      end
      req_valid   <= start && !busy;
      entry_valid <= valid_next;
      fill_count  <= fill_next;
      done        <= done_next;
      for (int i = 0; i < lcc_pkg::NUM_ENTRIES; i++) begin
        entry_rank[i] <= rank_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    req_opcode   <= opcode;
    req_offset   <= offset;
    req_length   <= length;
    if (tag_we) begin
      entry_tag[victim] <= req_tag;
    end
    status       <= status_next;
    hit          <= hit_next;
    slot         <= slot_next;
    fetch_base   <= fetch_base_next;
    evicted      <= evicted_next;
    evicted_base <= evicted_base_next;
    chunk_offset <= coff_next;
    out_length   <= olen_next;
  end

endmodule

[tb/lcc_lookup_monitor.sv]
// Result predictor and comparator for the chunk cache lookup unit.
// Watches the request, config and result ports; depends on lcc_pkg.
module lcc_lookup_monitor
  import lcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        opcode,
  input  logic [31:0] offset,
  input  logic [31:0] length,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        done,
  input  logic [1:0]  status,
  input  logic        hit,
  input  logic [3:0]  slot,
  input  logic [31:0] fetch_base,
  input  logic        evicted,
  input  logic [31:0] evicted_base,
  input  logic [11:0] chunk_offset,
  input  logic [12:0] out_length,
  output int          errors,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic [31:0]         fetch_base;
    logic                evicted;
    logic [31:0]         evicted_base;
    logic [COFF_W-1:0]   chunk_offset;
    logic [OLEN_W-1:0]   out_length;
  } lookup_result_t;

  logic [31:0]    file_size;
  tag_t           tags  [NUM_ENTRIES];
  logic           valid [NUM_ENTRIES];
  rank_t          age   [NUM_ENTRIES];
  int             fill;
  lookup_result_t pending_results[$];

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  function automatic void reset_tag_store();
    file_size = '0;
    fill      = 0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      tags[i]  = '0;
      valid[i] = 1'b0;
      age[i]   = '0;
    end
  endfunction

  function automatic lookup_result_t predict_lookup(input logic op, input logic [31:0] off,
                                                    input logic [31:0] len);
    lookup_result_t r;
    logic [32:0]    n;
    logic [12:0]    room;
    tag_t           t;
    rank_t          old_age;
    rank_t          worst;
    int             idx;
    r = '0;
    if (op == OP_CLEAR) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        valid[i] = 1'b0;
        age[i]   = '0;
      end
      fill     = 0;
      r.status = STATUS_CLEARED;
      return r;
    end
    if (len == 0 || off >= file_size) begin
      r.status = STATUS_REJECTED;
      return r;
    end
    n = {1'b0, len};
    if ({1'b0, off} + {1'b0, len} > {1'b0, file_size})
      n = {1'b0, file_size - off};
    room = 13'(CHUNK_BYTES) - 13'(off[CHUNK_SHIFT-1:0]);
    if (n > {20'b0, room})
      n = {20'b0, room};
    t              = off[ADDR_BITS-1:CHUNK_SHIFT];
    r.status       = STATUS_SERVED;
    r.chunk_offset = off[CHUNK_SHIFT-1:0];
    r.out_length   = n[OLEN_W-1:0];
    r.fetch_base   = {t, {CHUNK_SHIFT{1'b0}}};

    idx = -1;
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (idx < 0 && valid[i] && tags[i] == t)
        idx = i;

    if (idx >= 0) begin
      r.hit   = 1'b1;
      old_age = age[idx];
      for (int i = 0; i < NUM_ENTRIES; i++)
        if (valid[i] && age[i] < old_age)
          age[i] = age[i] + 1'b1;
      age[idx] = '0;
    end else begin
      if (fill < NUM_ENTRIES)
        for (int i = 0; i < NUM_ENTRIES; i++)
          if (idx < 0 && !valid[i])
            idx = i;
      if (idx < 0) begin
        // full: replace the least recent valid entry, last one on a tie
        worst = '0;
        idx   = 0;
        for (int i = 0; i < NUM_ENTRIES; i++)
          if (valid[i] && age[i] >= worst) begin
            worst = age[i];
            idx   = i;
          end
        r.evicted      = 1'b1;
        r.evicted_base = {tags[idx], {CHUNK_SHIFT{1'b0}}};
        valid[idx]     = 1'b0;
      end else begin
        fill++;
      end
      for (int i = 0; i < NUM_ENTRIES; i++)
        if (valid[i] && age[i] < rank_t'(NUM_ENTRIES - 1))
          age[i] = age[i] + 1'b1;
      tags[idx]  = t;
      valid[idx] = 1'b1;
      age[idx]   = '0;
    end
    r.slot = SLOT_W'(idx);
    return r;
  endfunction

  task automatic note_mismatch(input string what, input lookup_result_t want,
                               input lookup_result_t got);
    errors++;
    if (errors <= 10)
      $display("%0t ERROR %s: exp st=%0d hit=%0d slot=%0d fb=%h ev=%0d eb=%h co=%h len=%0d | got st=%0d hit=%0d slot=%0d fb=%h ev=%0d eb=%h co=%h len=%0d",
               $time, what,
               want.status, want.hit, want.slot, want.fetch_base, want.evicted,
               want.evicted_base, want.chunk_offset, want.out_length,
               got.status, got.hit, got.slot, got.fetch_base, got.evicted,
               got.evicted_base, got.chunk_offset, got.out_length);
  endtask

  always @(posedge clk) begin : watch
    lookup_result_t got;
    lookup_result_t want;
    if (rst) begin
      reset_tag_store();
      pending_results.delete();
    end else begin
      if (done) begin
        got = {status, hit, slot, fetch_base, evicted, evicted_base, chunk_offset,
               out_length};
        if (pending_results.size() == 0) begin
          note_mismatch("result with no request pending", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want)
            note_mismatch("result mismatch", want, got);
        end
      end
      if (cfg_we)
        file_size = cfg_data;
      if (start && !busy)
        pending_results.push_back(predict_lookup(opcode, offset, length));
    end
    outstanding = pending_results.size();
  end

endmodule

[tb/lru_chunk_cache_lookup_unit_tb.sv]
// Top-level testbench for lru_chunk_cache_lookup_unit: clock, reset and request stimulus.
// Checking is done by lcc_lookup_monitor; depends on lcc_pkg and the unit.
module lru_chunk_cache_lookup_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcc_pkg::*;

  localparam int CYCLE_LIMIT = 150000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        start    = 1'b0;
  logic        opcode   = OP_READ;
  logic [31:0] offset   = '0;
  logic [31:0] length   = '0;
  logic        cfg_we   = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic        hit;
  logic [3:0]  slot;
  logic [31:0] fetch_base;
  logic        evicted;
  logic [31:0] evicted_base;
  logic [11:0] chunk_offset;
  logic [12:0] out_length;
  int          errors;
  int          outstanding;
  int          cycles = 0;

  logic [31:0] cur_file_size;
  int          pool_base;
  int          pool_size;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lru_chunk_cache_lookup_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .offset       (offset),
    .length       (length),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .done         (done),
    .status       (status),
    .hit          (hit),
    .slot         (slot),
    .fetch_base   (fetch_base),
    .evicted      (evicted),
    .evicted_base (evicted_base),
    .chunk_offset (chunk_offset),
    .out_length   (out_length)
  );

  lcc_lookup_monitor mon (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .offset       (offset),
    .length       (length),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .done         (done),
    .status       (status),
    .hit          (hit),
    .slot         (slot),
    .fetch_base   (fetch_base),
    .evicted      (evicted),
    .evicted_base (evicted_base),
    .chunk_offset (chunk_offset),
    .out_length   (out_length),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL lru_chunk_cache_lookup_unit");
      $finish;
    end
  end

  task automatic issue(input logic op, input logic [31:0] off, input logic [31:0] len);
    start  <= 1'b1;
    opcode <= op;
    offset <= off;
    length <= len;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_file_size(input logic [31:0] value);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_file_size = value;
  endtask

  function automatic logic [31:0] pool_offset();
    return (32'(pool_base + $urandom_range(pool_size - 1)) << CHUNK_SHIFT)
           | 32'($urandom_range(CHUNK_BYTES - 1));
  endfunction

  task automatic run_phase(input logic [31:0] fsize, input int count, input bit idling);
    longint      nchunks;
    int          sel;
    logic        op;
    logic [31:0] off;
    logic [31:0] len;
    write_file_size(fsize);
    nchunks = (longint'(fsize) + CHUNK_BYTES - 1) >> CHUNK_SHIFT;
    if (nchunks == 0) begin
      pool_size = 1;
      pool_base = 0;
    end else begin
      pool_size = $urandom_range(12, 24);
      if (pool_size > nchunks)
        pool_size = int'(nchunks);
      pool_base = $urandom_range(int'(nchunks) - pool_size);
    end
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      op  = OP_READ;
      off = pool_offset();
      case ($urandom_range(3))
        0: len = $urandom_range(1, 32);
        1: len = $urandom_range(1, 2 * CHUNK_BYTES);
        2: len = $urandom;
        default: len = CHUNK_BYTES - (off % CHUNK_BYTES);
      endcase
      if (sel < 3) begin
        op  = OP_CLEAR;
        off = $urandom;
        len = $urandom;
      end else if (sel < 13) begin
        off = $urandom;
        len = $urandom;
      end else if (sel < 18) begin
        len = '0;
      end else if (sel < 24) begin
        off = (cur_file_size > 200) ? cur_file_size - $urandom_range(1, 200)
                                    : 32'($urandom_range(300));
      end
      if (idling && $urandom_range(3) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      issue(op, off, len);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // file size is zero after reset: reads are rejected
    issue(OP_READ, 32'h0000_0000, 32'h0000_0010);
    issue(OP_CLEAR, 32'h0000_0000, 32'h0000_0000);

    write_file_size(32'hFFFF_FFFF);
    issue(OP_READ, 32'h0000_0000, 32'h0000_0000);
    issue(OP_READ, 32'hFFFF_FFFF, 32'h0000_0001);
    issue(OP_READ, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    issue(OP_READ, 32'h0000_0000, 32'hFFFF_FFFF);
    issue(OP_READ, 32'h0000_0FFF, 32'h0000_0002);
    // fill every slot, then evict the two oldest chunks
    for (int i = 1; i <= 16; i++)
      issue(OP_READ, (32'(i) << CHUNK_SHIFT) + 32'(i * 7), 32'd100);
    issue(OP_READ, 32'h0000_1000, 32'h0000_1000);
    issue(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(OP_READ, 32'h0000_5000, 32'h0000_0800);

    run_phase(32'(40 * CHUNK_BYTES + 77), 200, 1'b1);
    run_phase(32'(10 * CHUNK_BYTES + 2000), 150, 1'b1);
    run_phase($urandom, 200, 1'b1);
    run_phase(32'hFFFF_FFFF, 200, 1'b1);
    run_phase(32'd1, 60, 1'b1);
    run_phase(32'd0, 40, 1'b1);
    run_phase(32'(20 * CHUNK_BYTES + $urandom_range(CHUNK_BYTES - 1)), 150, 1'b1);
    run_phase(32'($urandom_range(17 * CHUNK_BYTES, 64 * CHUNK_BYTES)), 200, 1'b0);

    drain();
    if (errors == 0 && outstanding == 0) begin
      $display("PASS lru_chunk_cache_lookup_unit");
    end else begin
      $display("FAIL lru_chunk_cache_lookup_unit");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/lcc_pkg.sv
rtl/lru_chunk_cache_lookup_unit.sv
tb/lcc_lookup_monitor.sv
tb/lru_chunk_cache_lookup_unit_tb.sv
